>>> hdl/go_back_n_sender_macros.svh
// Assertion macros shared by the go-back-N sender checker.
// Expects i_clk and i_rst_n in the scope where a macro is used.
`ifndef GO_BACK_N_SENDER_MACROS_SVH
`define GO_BACK_N_SENDER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define GBN_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("go_back_n_sender port check failed");

// Next-cycle implication, sampled on the rising clock edge.
`define GBN_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("go_back_n_sender port check failed");

`endif

>>> hdl/gbn_pkg.sv
// Shared types, codes and defaults for the go-back-N sender.
// No dependencies; the sender, the checker and the bench use it by scoped name.
`timescale 1ns / 1ps

package gbn_pkg;

    localparam int DEF_WIN_SIZE  = 4;
    localparam int DEF_SEQ_COUNT = 8;
    localparam int DEF_WORD_BITS = 32;

    // Fixed port field widths.
    localparam int CMD_W  = 2;
    localparam int MSG_W  = 32;
    localparam int PSEQ_W = 3;

    // Widest internal sequence number and payload word.
    localparam int MAX_SEQ_W  = 8;
    localparam int MAX_WORD_W = 64;

    typedef enum logic [1:0] {
        CMD_SEND    = 2'd0,
        CMD_ACK     = 2'd1,
        CMD_TIMEOUT = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        ACK_IGNORED = 2'd0,
        ACK_OK      = 2'd1,
        ACK_BAD_SUM = 2'd2,
        ACK_OUTSIDE = 2'd3
    } t_ack_status;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SEND_WR,
        S_SEND_NXT,
        S_ACK_OFF,
        S_ACK_CHK,
        S_ACK_BASE,
        S_TO_READ,
        S_TO_EMIT,
        S_SINGLE
    } t_state;

    typedef struct packed {
        logic               pkt_valid;
        logic [PSEQ_W-1:0]  pkt_seq;
        logic [MSG_W-1:0]   pkt_word;
        logic               send_ok;
        t_ack_status        ack_status;
        logic               timer_start;
        logic [PSEQ_W-1:0]  start_seq;
        logic               timer_stop;
        logic [PSEQ_W-1:0]  stop_seq;
        logic               last;
    } t_result;

    // Reduces a 3-bit ack number into the sequence space by repeated subtraction.
    // The modulus is at least two, so three subtractions always suffice.
    function automatic logic [PSEQ_W-1:0] reduce_ack(input logic [PSEQ_W-1:0] v,
                                                     input int unsigned seq_count);
        logic [PSEQ_W-1:0] r;
        r = v;
        for (int k = 0; k < 3; k++) begin
            if (32'(r) >= seq_count) begin
                r = PSEQ_W'(32'(r) - seq_count);
            end
        end
        return r;
    endfunction

endpackage

>>> hdl/gbn_alu.sv
// Shared modular adder of the go-back-N sender: (a + b) folded once by m.
// Used for window slots and sequence numbers alike; depends on nothing.
`timescale 1ns / 1ps

module gbn_alu #(
    parameter int AW = 9
) (
    input  logic [AW-1:0] i_a,
    input  logic [AW-1:0] i_b,
    input  logic [AW-1:0] i_m,
    output logic [AW-1:0] o_y
);

    logic [AW-1:0] w_sum;

    // Operands are chosen so that the sum stays below twice the modulus.
    assign w_sum = i_a + i_b;
    assign o_y   = (w_sum >= i_m) ? (w_sum - i_m) : w_sum;

endmodule

>>> hdl/gbn_store.sv
// Window buffer of the go-back-N sender: one write port, one registered read port.
// Depends on nothing; contents are undefined until written.
`timescale 1ns / 1ps

module gbn_store #(
    parameter int DEPTH  = 4,
    parameter int ADDR_W = 2,
    parameter int DW     = 32
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DW-1:0]     i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DW-1:0]     o_rdata
);

    logic [DW-1:0] r_mem [DEPTH];
    logic [DW-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/go_back_n_sender.sv
// Go-back-N sender window. A new item is taken only while idle. A send writes its slot and then
// advances the sequence number, unless refused; an ack finds its offset, checks it against the
// window, then moves the base; a timeout reads and resends each buffered packet in turn.
// Each result strobes for one cycle and is never stalled.
// Synchronous active-low reset clears state, base, next sequence, count, head, timer flag and strobe only.
`timescale 1ns / 1ps

module go_back_n_sender #(
    parameter int WIN_SIZE  = gbn_pkg::DEF_WIN_SIZE,
    parameter int SEQ_COUNT = gbn_pkg::DEF_SEQ_COUNT,
    parameter int WORD_BITS = gbn_pkg::DEF_WORD_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  logic [gbn_pkg::CMD_W-1:0]   i_cmd,
    input  logic [gbn_pkg::MSG_W-1:0]   i_msg_word,
    input  logic [gbn_pkg::PSEQ_W-1:0]  i_ack_seq,
    input  logic                        i_ack_check_ok,
    input  logic [gbn_pkg::PSEQ_W-1:0]  i_expired_seq,
    output logic                        o_strobe,
    output logic                        o_pkt_valid,
    output logic [gbn_pkg::PSEQ_W-1:0]  o_pkt_seq,
    output logic [gbn_pkg::MSG_W-1:0]   o_pkt_word,
    output logic                        o_send_ok,
    output logic [1:0]                  o_ack_status,
    output logic                        o_timer_start,
    output logic [gbn_pkg::PSEQ_W-1:0]  o_start_seq,
    output logic                        o_timer_stop,
    output logic [gbn_pkg::PSEQ_W-1:0]  o_stop_seq,
    output logic                        o_last
);

    localparam int SEQ_W  = (SEQ_COUNT > 1) ? $clog2(SEQ_COUNT) : 1;
    localparam int SLOT_W = (WIN_SIZE > 1) ? $clog2(WIN_SIZE) : 1;
    localparam int CNT_W  = $clog2(WIN_SIZE + 1);
    localparam int AW     = ((SEQ_W > CNT_W) ? SEQ_W : CNT_W) + 1;

    gbn_pkg::t_state  r_state, n_state;
    logic [SEQ_W-1:0] r_base, n_base;
    logic [SEQ_W-1:0] r_next, n_next;
    logic [CNT_W-1:0] r_in_flight, n_in_flight;
    logic             r_timer_on, n_timer_on;
    logic [SLOT_W-1:0] r_head, n_head;
    logic             r_strobe, n_strobe;

    logic [gbn_pkg::CMD_W-1:0]  r_cmd, n_cmd;
    logic [WORD_BITS-1:0]       r_word, n_word;
    logic [SEQ_W-1:0]           r_ack, n_ack;
    logic                       r_chk, n_chk;
    logic [gbn_pkg::PSEQ_W-1:0] r_exp, n_exp;
    logic [SEQ_W-1:0]           r_off, n_off;
    logic [CNT_W-1:0]           r_idx, n_idx;
    logic [SLOT_W-1:0]          r_rd_slot, n_rd_slot;
    logic [SEQ_W-1:0]           r_rd_seq, n_rd_seq;
    gbn_pkg::t_result           r_res, n_res;

    logic [AW-1:0]        alu_a, alu_b, alu_m, alu_y;
    logic                 mem_we, mem_re;
    logic [SLOT_W-1:0]    mem_waddr, mem_raddr;
    logic [WORD_BITS-1:0] mem_rdata;

    logic w_full, w_off_out, w_last_pkt;
    logic [gbn_pkg::MAX_WORD_W-1:0] w_msg_ext;
    logic [gbn_pkg::MAX_SEQ_W-1:0]  w_ack_ext;

    function automatic logic [gbn_pkg::PSEQ_W-1:0] f_port_seq(input logic [SEQ_W-1:0] s);
        logic [gbn_pkg::MAX_SEQ_W-1:0] t;
        t = gbn_pkg::MAX_SEQ_W'(s);
        return t[gbn_pkg::PSEQ_W-1:0];
    endfunction

    function automatic logic [gbn_pkg::MSG_W-1:0] f_port_word(input logic [WORD_BITS-1:0] w);
        logic [gbn_pkg::MAX_WORD_W-1:0] t;
        t = gbn_pkg::MAX_WORD_W'(w);
        return t[gbn_pkg::MSG_W-1:0];
    endfunction

    gbn_alu #(
        .AW (AW)
    ) u_alu (
        .i_a (alu_a),
        .i_b (alu_b),
        .i_m (alu_m),
        .o_y (alu_y)
    );

    gbn_store #(
        .DEPTH  (WIN_SIZE),
        .ADDR_W (SLOT_W),
        .DW     (WORD_BITS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (r_word),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign w_msg_ext  = gbn_pkg::MAX_WORD_W'(i_msg_word);
    assign w_ack_ext  = gbn_pkg::MAX_SEQ_W'(gbn_pkg::reduce_ack(i_ack_seq, SEQ_COUNT));
    assign w_full     = (r_in_flight >= CNT_W'(WIN_SIZE));
    assign w_off_out  = (AW'(r_off) >= AW'(r_in_flight));
    assign w_last_pkt = ((CNT_W + 1)'(r_idx) + 1'b1) == (CNT_W + 1)'(r_in_flight);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            gbn_pkg::S_IDLE: begin
                if (start) begin
                    unique case (i_cmd)
                        gbn_pkg::CMD_SEND:    n_state = gbn_pkg::S_SEND_WR;
                        gbn_pkg::CMD_ACK:     n_state = gbn_pkg::S_ACK_OFF;
                        gbn_pkg::CMD_TIMEOUT: n_state = (r_in_flight == '0) ?
                                                        gbn_pkg::S_SINGLE : gbn_pkg::S_TO_READ;
                        default:              n_state = gbn_pkg::S_SINGLE;
                    endcase
                end
            end
            gbn_pkg::S_SEND_WR:  n_state = w_full ? gbn_pkg::S_IDLE : gbn_pkg::S_SEND_NXT;
            gbn_pkg::S_SEND_NXT: n_state = gbn_pkg::S_IDLE;
            gbn_pkg::S_ACK_OFF:  n_state = (r_in_flight == '0 || !r_chk) ?
                                           gbn_pkg::S_IDLE : gbn_pkg::S_ACK_CHK;
            gbn_pkg::S_ACK_CHK:  n_state = w_off_out ? gbn_pkg::S_IDLE : gbn_pkg::S_ACK_BASE;
            gbn_pkg::S_ACK_BASE: n_state = gbn_pkg::S_IDLE;
            gbn_pkg::S_TO_READ:  n_state = gbn_pkg::S_TO_EMIT;
            gbn_pkg::S_TO_EMIT:  n_state = w_last_pkt ? gbn_pkg::S_IDLE : gbn_pkg::S_TO_READ;
            gbn_pkg::S_SINGLE:   n_state = gbn_pkg::S_IDLE;
            default:             n_state = gbn_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_base      = r_base;
        n_next      = r_next;
        n_in_flight = r_in_flight;
        n_timer_on  = r_timer_on;
        n_head      = r_head;
        n_strobe    = 1'b0;
        n_cmd       = r_cmd;
        n_word      = r_word;
        n_ack       = r_ack;
        n_chk       = r_chk;
        n_exp       = r_exp;
        n_off       = r_off;
        n_idx       = r_idx;
        n_rd_slot   = r_rd_slot;
        n_rd_seq    = r_rd_seq;
        n_res       = r_res;
        alu_a       = '0;
        alu_b       = '0;
        alu_m       = AW'(SEQ_COUNT);
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_waddr   = r_head;
        mem_raddr   = r_rd_slot;

        unique case (r_state)
            gbn_pkg::S_IDLE: begin
                if (start) begin
                    n_cmd     = i_cmd;
                    n_word    = w_msg_ext[WORD_BITS-1:0];
                    n_ack     = w_ack_ext[SEQ_W-1:0];
                    n_chk     = i_ack_check_ok;
                    n_exp     = i_expired_seq;
                    n_idx     = '0;
                    n_rd_slot = r_head;
                    n_rd_seq  = r_base;
                end
            end
            gbn_pkg::S_SEND_WR: begin
                // Slot of the new packet is head plus count, folded by the window size.
                alu_a    = AW'(r_head);
                alu_b    = AW'(r_in_flight);
                alu_m    = AW'(WIN_SIZE);
                n_strobe = 1'b1;
                n_res    = '0;
                n_res.last = 1'b1;
                if (!w_full) begin
                    mem_we           = 1'b1;
                    mem_waddr        = alu_y[SLOT_W-1:0];
                    n_in_flight      = r_in_flight + 1'b1;
                    n_res.pkt_valid  = 1'b1;
                    n_res.pkt_seq    = f_port_seq(r_next);
                    n_res.pkt_word   = f_port_word(r_word);
                    n_res.send_ok    = 1'b1;
                    if (!r_timer_on) begin
                        n_timer_on        = 1'b1;
                        n_res.timer_start = 1'b1;
                        n_res.start_seq   = f_port_seq(r_next);
                    end
                end
            end
            gbn_pkg::S_SEND_NXT: begin
                alu_a  = AW'(r_next);
                alu_b  = AW'(1);
                n_next = alu_y[SEQ_W-1:0];
            end
            gbn_pkg::S_ACK_OFF: begin
                if (r_in_flight == '0) begin
                    n_strobe         = 1'b1;
                    n_res            = '0;
                    n_res.ack_status = gbn_pkg::ACK_IGNORED;
                    n_res.last       = 1'b1;
                end else if (!r_chk) begin
                    n_strobe         = 1'b1;
                    n_res            = '0;
                    n_res.ack_status = gbn_pkg::ACK_BAD_SUM;
                    n_res.last       = 1'b1;
                end else begin
                    // Distance of the ack from the window base.
                    alu_a = AW'(r_ack);
                    alu_b = AW'(SEQ_COUNT) - AW'(r_base);
                    n_off = alu_y[SEQ_W-1:0];
                end
            end
            gbn_pkg::S_ACK_CHK: begin
                if (w_off_out) begin
                    n_strobe         = 1'b1;
                    n_res            = '0;
                    n_res.ack_status = gbn_pkg::ACK_OUTSIDE;
                    n_res.last       = 1'b1;
                end else begin
                    n_in_flight = r_in_flight - (CNT_W'(r_off) + 1'b1);
                    alu_a       = AW'(r_head);
                    alu_b       = AW'(r_off) + 1'b1;
                    alu_m       = AW'(WIN_SIZE);
                    n_head      = alu_y[SLOT_W-1:0];
                end
            end
            gbn_pkg::S_ACK_BASE: begin
                // Count is already reduced here; the new base is ack plus one.
                alu_a            = AW'(r_ack);
                alu_b            = AW'(1);
                n_base           = alu_y[SEQ_W-1:0];
                n_timer_on       = (r_in_flight != '0);
                n_strobe         = 1'b1;
                n_res            = '0;
                n_res.ack_status = gbn_pkg::ACK_OK;
                n_res.timer_stop = 1'b1;
                n_res.stop_seq   = f_port_seq(r_base);
                n_res.last       = 1'b1;
                if (r_in_flight != '0) begin
                    n_res.timer_start = 1'b1;
                    n_res.start_seq   = f_port_seq(alu_y[SEQ_W-1:0]);
                end
            end
            gbn_pkg::S_TO_READ: begin
                mem_re    = 1'b1;
                alu_a     = AW'(r_rd_slot);
                alu_b     = AW'(1);
                alu_m     = AW'(WIN_SIZE);
                n_rd_slot = alu_y[SLOT_W-1:0];
            end
            gbn_pkg::S_TO_EMIT: begin
                alu_a           = AW'(r_rd_seq);
                alu_b           = AW'(1);
                n_rd_seq        = alu_y[SEQ_W-1:0];
                n_idx           = r_idx + 1'b1;
                n_strobe        = 1'b1;
                n_res           = '0;
                n_res.pkt_valid = 1'b1;
                n_res.pkt_seq   = f_port_seq(r_rd_seq);
                n_res.pkt_word  = f_port_word(mem_rdata);
                n_res.last      = w_last_pkt;
                if (r_idx == '0) begin
                    n_res.timer_stop  = 1'b1;
                    n_res.stop_seq    = r_exp;
                    n_res.timer_start = 1'b1;
                    n_res.start_seq   = r_exp;
                end
            end
            gbn_pkg::S_SINGLE: begin
                // Timeout with nothing buffered still restarts the timer.
                n_strobe   = 1'b1;
                n_res      = '0;
                n_res.last = 1'b1;
                if (r_cmd == gbn_pkg::CMD_TIMEOUT) begin
                    n_res.timer_stop  = 1'b1;
                    n_res.stop_seq    = r_exp;
                    n_res.timer_start = 1'b1;
                    n_res.start_seq   = r_exp;
                end
            end
            default: begin
                n_strobe = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= gbn_pkg::S_IDLE;
            r_base      <= '0;
            r_next      <= '0;
            r_in_flight <= '0;
            r_timer_on  <= 1'b0;
            r_head      <= '0;
            r_strobe    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_base      <= n_base;
            r_next      <= n_next;
            r_in_flight <= n_in_flight;
            r_timer_on  <= n_timer_on;
            r_head      <= n_head;
            r_strobe    <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd     <= n_cmd;
        r_word    <= n_word;
        r_ack     <= n_ack;
        r_chk     <= n_chk;
        r_exp     <= n_exp;
        r_off     <= n_off;
        r_idx     <= n_idx;
        r_rd_slot <= n_rd_slot;
        r_rd_seq  <= n_rd_seq;
        r_res     <= n_res;
    end

    assign busy          = (r_state != gbn_pkg::S_IDLE);
    assign o_strobe      = r_strobe;
    assign o_pkt_valid   = r_res.pkt_valid;
    assign o_pkt_seq     = r_res.pkt_seq;
    assign o_pkt_word    = r_res.pkt_word;
    assign o_send_ok     = r_res.send_ok;
    assign o_ack_status  = r_res.ack_status;
    assign o_timer_start = r_res.timer_start;
    assign o_start_seq   = r_res.start_seq;
    assign o_timer_stop  = r_res.timer_stop;
    assign o_stop_seq    = r_res.stop_seq;
    assign o_last        = r_res.last;

endmodule

>>> hdl/gbn_checker.sv
// Port-level checks for the go-back-N sender, bound to the top level.
// Depends on gbn_pkg and go_back_n_sender_macros.svh.
`timescale 1ns / 1ps
`include "go_back_n_sender_macros.svh"

module gbn_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        start,
    input logic                        busy,
    input logic                        o_strobe,
    input logic                        o_pkt_valid,
    input logic [gbn_pkg::PSEQ_W-1:0]  o_pkt_seq,
    input logic [gbn_pkg::MSG_W-1:0]   o_pkt_word,
    input logic                        o_send_ok,
    input logic                        o_timer_start,
    input logic [gbn_pkg::PSEQ_W-1:0]  o_start_seq,
    input logic                        o_last
);

    // Every accepted item makes the block busy in the next cycle.
    `GBN_ASSERT_NXT(a_accept_busy, start && !busy, busy)
    // More results of the same item are still to come while not on the last one.
    `GBN_ASSERT_IMP(a_more_busy, o_strobe && !o_last, busy)
    // A result without a packet carries a zero sequence number and payload.
    `GBN_ASSERT_IMP(a_nopkt_zero, o_strobe && !o_pkt_valid, o_pkt_seq == '0 && o_pkt_word == '0)
    // An accepted send always carries its packet and is the last result of its item.
    `GBN_ASSERT_IMP(a_send_pkt, o_strobe && o_send_ok, o_pkt_valid && o_last)
    // A start tag only appears with a timer start.
    `GBN_ASSERT_IMP(a_start_tag, o_strobe && !o_timer_start, o_start_seq == '0)

endmodule

bind go_back_n_sender gbn_checker u_gbn_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .o_strobe      (o_strobe),
    .o_pkt_valid   (o_pkt_valid),
    .o_pkt_seq     (o_pkt_seq),
    .o_pkt_word    (o_pkt_word),
    .o_send_ok     (o_send_ok),
    .o_timer_start (o_timer_start),
    .o_start_seq   (o_start_seq),
    .o_last        (o_last)
);

>>> bench/go_back_n_sender_test.sv
// Self-checking bench for the go-back-N sender window: directed table, then random traffic.
// Depends on gbn_pkg and go_back_n_sender from the hdl folder; results checked in order.
`timescale 1ns / 1ps

module go_back_n_sender_test;

    localparam int WIN = gbn_pkg::DEF_WIN_SIZE;
    localparam int SEQS = gbn_pkg::DEF_SEQ_COUNT;
    localparam int SLOT_W = (WIN > 1) ? $clog2(WIN) : 1;
    localparam int CLK_PERIOD = 10;
    localparam int DIR_W = 5;
    localparam int DIR_DEPTH = 1 << DIR_W;
    localparam int DUE_W = 6;
    localparam int DUE_DEPTH = 1 << DUE_W;
    localparam logic [gbn_pkg::CMD_W-1:0] CMD_RESERVED = 2'd3;

    typedef struct {
        logic [gbn_pkg::CMD_W-1:0]  cmd;
        logic [gbn_pkg::MSG_W-1:0]  word;
        logic [gbn_pkg::PSEQ_W-1:0] ack;
        logic                       ok;
        logic [gbn_pkg::PSEQ_W-1:0] expired;
        bit                         fixed;
        gbn_pkg::t_result           want;
    } t_stim_row;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic start;
    logic busy;
    logic [gbn_pkg::CMD_W-1:0] i_cmd;
    logic [gbn_pkg::MSG_W-1:0] i_msg_word;
    logic [gbn_pkg::PSEQ_W-1:0] i_ack_seq;
    logic i_ack_check_ok;
    logic [gbn_pkg::PSEQ_W-1:0] i_expired_seq;
    logic o_strobe;
    logic o_pkt_valid;
    logic [gbn_pkg::PSEQ_W-1:0] o_pkt_seq;
    logic [gbn_pkg::MSG_W-1:0] o_pkt_word;
    logic o_send_ok;
    logic [1:0] o_ack_status;
    logic o_timer_start;
    logic [gbn_pkg::PSEQ_W-1:0] o_start_seq;
    logic o_timer_stop;
    logic [gbn_pkg::PSEQ_W-1:0] o_stop_seq;
    logic o_last;

    // Shadow copy of the sender window.
    logic [gbn_pkg::PSEQ_W-1:0] win_base;
    logic [gbn_pkg::PSEQ_W-1:0] seq_next;
    int unsigned pending;
    bit shadow_timer_on;
    logic [gbn_pkg::MSG_W-1:0] slot_word [WIN];
    int unsigned head_idx;

    // Expected results in order, kept in a ring with free-running indexes.
    gbn_pkg::t_result due_mem [DUE_DEPTH];
    logic [DUE_W-1:0] due_wr;
    logic [DUE_W-1:0] due_rd;
    t_stim_row dir_rows [DIR_DEPTH];
    int dir_count;
    bit row_fixed;
    gbn_pkg::t_result row_want;
    int bad_results;

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    go_back_n_sender u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_cmd          (i_cmd),
        .i_msg_word     (i_msg_word),
        .i_ack_seq      (i_ack_seq),
        .i_ack_check_ok (i_ack_check_ok),
        .i_expired_seq  (i_expired_seq),
        .o_strobe       (o_strobe),
        .o_pkt_valid    (o_pkt_valid),
        .o_pkt_seq      (o_pkt_seq),
        .o_pkt_word     (o_pkt_word),
        .o_send_ok      (o_send_ok),
        .o_ack_status   (o_ack_status),
        .o_timer_start  (o_timer_start),
        .o_start_seq    (o_start_seq),
        .o_timer_stop   (o_timer_stop),
        .o_stop_seq     (o_stop_seq),
        .o_last         (o_last)
    );

    function automatic int unsigned due_count();
        logic [DUE_W-1:0] d;
        d = due_wr - due_rd;
        return int'(d);
    endfunction

    function automatic void due_put(input gbn_pkg::t_result r);
        due_mem[due_wr] = r;
        due_wr = due_wr + 1'b1;
    endfunction

    function automatic gbn_pkg::t_result due_take();
        gbn_pkg::t_result r;
        r = due_mem[due_rd];
        due_rd = due_rd + 1'b1;
        return r;
    endfunction

    // Applies one accepted item to the shadow window and queues the results it causes.
    task automatic sender_step(input logic [gbn_pkg::CMD_W-1:0] cmd,
                               input logic [gbn_pkg::MSG_W-1:0] word,
                               input logic [gbn_pkg::PSEQ_W-1:0] ack, input logic ok,
                               input logic [gbn_pkg::PSEQ_W-1:0] expired);
        gbn_pkg::t_result r;
        int unsigned off;
        int unsigned k;
        r = '0;
        case (cmd)
            gbn_pkg::CMD_SEND: begin
                r.last = 1'b1;
                if (pending < WIN) begin
                    slot_word[SLOT_W'((head_idx + pending) % WIN)] = word;
                    pending++;
                    r.pkt_valid = 1'b1;
                    r.pkt_seq = seq_next;
                    r.pkt_word = word;
                    r.send_ok = 1'b1;
                    if (!shadow_timer_on) begin
                        shadow_timer_on = 1'b1;
                        r.timer_start = 1'b1;
                        r.start_seq = seq_next;
                    end
                    seq_next = gbn_pkg::PSEQ_W'((int'(seq_next) + 1) % SEQS);
                end
                due_put(r);
            end
            gbn_pkg::CMD_ACK: begin
                r.last = 1'b1;
                off = (int'(ack) % SEQS + SEQS - int'(win_base)) % SEQS;
                if (pending == 0) begin
                    r.ack_status = gbn_pkg::ACK_IGNORED;
                end else if (!ok) begin
                    r.ack_status = gbn_pkg::ACK_BAD_SUM;
                end else if (off >= pending) begin
                    r.ack_status = gbn_pkg::ACK_OUTSIDE;
                end else begin
                    r.ack_status = gbn_pkg::ACK_OK;
                    r.timer_stop = 1'b1;
                    r.stop_seq = win_base;
                    pending -= off + 1;
                    head_idx = (head_idx + off + 1) % WIN;
                    win_base = gbn_pkg::PSEQ_W'((int'(ack) % SEQS + 1) % SEQS);
                    shadow_timer_on = (pending != 0);
                    if (pending != 0) begin
                        r.timer_start = 1'b1;
                        r.start_seq = win_base;
                    end
                end
                due_put(r);
            end
            gbn_pkg::CMD_TIMEOUT: begin
                if (pending == 0) begin
                    r.timer_stop = 1'b1;
                    r.stop_seq = expired;
                    r.timer_start = 1'b1;
                    r.start_seq = expired;
                    r.last = 1'b1;
                    due_put(r);
                end
                // Go back to the base and resend the whole window, oldest first.
                for (k = 0; k < pending; k++) begin
                    r = '0;
                    r.pkt_valid = 1'b1;
                    r.pkt_seq = gbn_pkg::PSEQ_W'((int'(win_base) + k) % SEQS);
                    r.pkt_word = slot_word[SLOT_W'((head_idx + k) % WIN)];
                    if (k == 0) begin
                        r.timer_stop = 1'b1;
                        r.stop_seq = expired;
                        r.timer_start = 1'b1;
                        r.start_seq = expired;
                    end
                    r.last = (k + 1 == pending);
                    due_put(r);
                end
            end
            default: begin
                r.last = 1'b1;
                due_put(r);
            end
        endcase
    endtask

    function automatic gbn_pkg::t_result single_result(input bit pv,
                                              input logic [gbn_pkg::PSEQ_W-1:0] seq,
                                              input logic [gbn_pkg::MSG_W-1:0] word,
                                              input bit sok,
                                              input gbn_pkg::t_ack_status st, input bit tst,
                                              input logic [gbn_pkg::PSEQ_W-1:0] sseq,
                                              input bit tsp,
                                              input logic [gbn_pkg::PSEQ_W-1:0] pseq);
        gbn_pkg::t_result r;
        r.pkt_valid = pv;
        r.pkt_seq = seq;
        r.pkt_word = word;
        r.send_ok = sok;
        r.ack_status = st;
        r.timer_start = tst;
        r.start_seq = sseq;
        r.timer_stop = tsp;
        r.stop_seq = pseq;
        r.last = 1'b1;
        return r;
    endfunction

    function automatic void add_row(input logic [gbn_pkg::CMD_W-1:0] cmd,
                                    input logic [gbn_pkg::MSG_W-1:0] word,
                                    input logic [gbn_pkg::PSEQ_W-1:0] ack, input logic ok,
                                    input logic [gbn_pkg::PSEQ_W-1:0] expired, input bit fixed,
                                    input gbn_pkg::t_result want);
        t_stim_row row;
        row.cmd = cmd;
        row.word = word;
        row.ack = ack;
        row.ok = ok;
        row.expired = expired;
        row.fixed = fixed;
        row.want = want;
        dir_rows[DIR_W'(dir_count)] = row;
        dir_count++;
    endfunction

    function automatic string show(input gbn_pkg::t_result r);
        return $sformatf({"pv=%0d seq=%0d word=%h ok=%0d ack=%0d ",
                          "start=%0d/%0d stop=%0d/%0d last=%0d"},
                         r.pkt_valid, r.pkt_seq, r.pkt_word, r.send_ok, r.ack_status,
                         r.timer_start, r.start_seq, r.timer_stop, r.stop_seq, r.last);
    endfunction

    always @(posedge i_clk) begin : watch
        gbn_pkg::t_result got;
        gbn_pkg::t_result want;
        logic [DUE_W-1:0] n_before;
        if (i_rst_n === 1'b1) begin
            // Check before queueing, so a stray result can never consume a fresh prediction.
            if (o_strobe !== 1'b0) begin
                got.pkt_valid = o_pkt_valid;
                got.pkt_seq = o_pkt_seq;
                got.pkt_word = o_pkt_word;
                got.send_ok = o_send_ok;
                got.ack_status = gbn_pkg::t_ack_status'(o_ack_status);
                got.timer_start = o_timer_start;
                got.start_seq = o_start_seq;
                got.timer_stop = o_timer_stop;
                got.stop_seq = o_stop_seq;
                got.last = o_last;
                if (due_count() == 0) begin
                    bad_results++;
                    if (bad_results <= 10) begin
                        $display("[%0t] result with nothing outstanding: %s", $time, show(got));
                    end
                end else begin
                    want = due_take();
                    if (got.pkt_valid !== want.pkt_valid || got.pkt_seq !== want.pkt_seq ||
                        got.pkt_word !== want.pkt_word || got.send_ok !== want.send_ok ||
                        got.ack_status !== want.ack_status ||
                        got.timer_start !== want.timer_start ||
                        got.start_seq !== want.start_seq ||
                        got.timer_stop !== want.timer_stop ||
                        got.stop_seq !== want.stop_seq || got.last !== want.last) begin
                        bad_results++;
                        if (bad_results <= 10) begin
                            $display("[%0t] mismatch", $time);
                            $display("  want: %s", show(want));
                            $display("  got : %s", show(got));
                        end
                    end
                end
            end
            if (start === 1'b1 && busy === 1'b0) begin
                n_before = due_wr;
                sender_step(i_cmd, i_msg_word, i_ack_seq, i_ack_check_ok, i_expired_seq);
                if (row_fixed) begin
                    // The typed-in result replaces what the predictor queued for this item.
                    due_wr = n_before;
                    due_put(row_want);
                end
            end
        end
    end

    task automatic drive_item(input logic [gbn_pkg::CMD_W-1:0] cmd,
                              input logic [gbn_pkg::MSG_W-1:0] word,
                              input logic [gbn_pkg::PSEQ_W-1:0] ack, input logic ok,
                              input logic [gbn_pkg::PSEQ_W-1:0] expired);
        start <= 1'b1;
        i_cmd <= cmd;
        i_msg_word <= word;
        i_ack_seq <= ack;
        i_ack_check_ok <= ok;
        i_expired_seq <= expired;
        do @(posedge i_clk); while (busy !== 1'b0);
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        start <= 1'b0;
        while (due_count() != 0) begin
            @(negedge i_clk);
        end
    endtask

    initial begin
        int pct;
        int pick;
        logic [gbn_pkg::CMD_W-1:0] cmd;
        logic [gbn_pkg::MSG_W-1:0] word;
        logic [gbn_pkg::PSEQ_W-1:0] ack;
        logic ok;
        logic [gbn_pkg::PSEQ_W-1:0] expired;

        i_rst_n = 1'b0;
        start = 1'b0;
        i_cmd = gbn_pkg::CMD_SEND;
        i_msg_word = '0;
        i_ack_seq = '0;
        i_ack_check_ok = 1'b0;
        i_expired_seq = '0;
        row_fixed = 1'b0;
        row_want = '0;
        bad_results = 0;
        win_base = '0;
        seq_next = '0;
        pending = 0;
        shadow_timer_on = 1'b0;
        head_idx = 0;
        due_wr = '0;
        due_rd = '0;
        dir_count = 0;

        // Window empty, then filled to the limit, errors, go-back, slides and a sequence wrap.
        add_row(gbn_pkg::CMD_ACK, 32'h0000_0000, 3'd5, 1'b1, 3'd2, 1'b1,
                single_result(0, 0, 0, 0, gbn_pkg::ACK_IGNORED, 0, 0, 0, 0));
        add_row(gbn_pkg::CMD_TIMEOUT, 32'hFFFF_FFFF, 3'd2, 1'b0, 3'd7, 1'b1,
                single_result(0, 0, 0, 0, gbn_pkg::ACK_IGNORED, 1, 7, 1, 7));
        add_row(CMD_RESERVED, 32'hDEAD_BEEF, 3'd7, 1'b1, 3'd7, 1'b1,
                single_result(0, 0, 0, 0, gbn_pkg::ACK_IGNORED, 0, 0, 0, 0));
        add_row(gbn_pkg::CMD_SEND, 32'hFFFF_FFFF, 3'd7, 1'b1, 3'd7, 1'b1,
                single_result(1, 0, 32'hFFFF_FFFF, 1, gbn_pkg::ACK_IGNORED, 1, 0, 0, 0));
        add_row(gbn_pkg::CMD_SEND, 32'h0000_0000, 3'd0, 1'b0, 3'd0, 1'b1,
                single_result(1, 1, 32'h0000_0000, 1, gbn_pkg::ACK_IGNORED, 0, 0, 0, 0));
        add_row(gbn_pkg::CMD_SEND, 32'hA5A5_A5A5, 3'd3, 1'b0, 3'd4, 1'b0, '0);
        add_row(gbn_pkg::CMD_SEND, 32'h5A5A_5A5A, 3'd4, 1'b1, 3'd3, 1'b0, '0);
        add_row(gbn_pkg::CMD_SEND, 32'h1234_5678, 3'd1, 1'b1, 3'd1, 1'b1,
                single_result(0, 0, 0, 0, gbn_pkg::ACK_IGNORED, 0, 0, 0, 0));
        add_row(gbn_pkg::CMD_ACK, 32'h8000_0001, 3'd0, 1'b0, 3'd6, 1'b1,
                single_result(0, 0, 0, 0, gbn_pkg::ACK_BAD_SUM, 0, 0, 0, 0));
        add_row(gbn_pkg::CMD_ACK, 32'h7FFF_FFFE, 3'd6, 1'b1, 3'd5, 1'b1,
                single_result(0, 0, 0, 0, gbn_pkg::ACK_OUTSIDE, 0, 0, 0, 0));
        add_row(gbn_pkg::CMD_TIMEOUT, 32'h0F0F_0F0F, 3'd7, 1'b0, 3'd0, 1'b0, '0);
        add_row(gbn_pkg::CMD_ACK, 32'h0, 3'd1, 1'b1, 3'd0, 1'b0, '0);
        add_row(gbn_pkg::CMD_SEND, 32'hCAFE_F00D, 3'd0, 1'b0, 3'd0, 1'b0, '0);
        add_row(gbn_pkg::CMD_SEND, 32'h0000_0001, 3'd0, 1'b0, 3'd0, 1'b0, '0);
        add_row(gbn_pkg::CMD_TIMEOUT, 32'h0, 3'd0, 1'b1, 3'd5, 1'b0, '0);
        add_row(gbn_pkg::CMD_ACK, 32'h0, 3'd3, 1'b1, 3'd0, 1'b0, '0);
        add_row(gbn_pkg::CMD_ACK, 32'h0, 3'd5, 1'b1, 3'd0, 1'b0, '0);
        // Timer already idle here; the timer commands still go out.
        add_row(gbn_pkg::CMD_TIMEOUT, 32'h0, 3'd0, 1'b0, 3'd3, 1'b0, '0);
        add_row(gbn_pkg::CMD_SEND, 32'h8000_0000, 3'd0, 1'b0, 3'd0, 1'b0, '0);
        add_row(gbn_pkg::CMD_SEND, 32'h0000_FFFF, 3'd0, 1'b0, 3'd0, 1'b0, '0);
        add_row(gbn_pkg::CMD_SEND, 32'hFFFF_0000, 3'd0, 1'b0, 3'd0, 1'b0, '0);
        add_row(gbn_pkg::CMD_SEND, 32'h3C3C_3C3C, 3'd0, 1'b0, 3'd0, 1'b0, '0);
        add_row(gbn_pkg::CMD_ACK, 32'h0, 3'd0, 1'b1, 3'd0, 1'b0, '0);
        add_row(gbn_pkg::CMD_TIMEOUT, 32'h0, 3'd0, 1'b0, 3'd2, 1'b0, '0);
        add_row(gbn_pkg::CMD_ACK, 32'h0, 3'd1, 1'b1, 3'd0, 1'b0, '0);

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int n = 0; n < dir_count; n++) begin
            @(negedge i_clk);
            row_fixed = dir_rows[DIR_W'(n)].fixed;
            row_want = dir_rows[DIR_W'(n)].want;
            drive_item(dir_rows[DIR_W'(n)].cmd, dir_rows[DIR_W'(n)].word,
                       dir_rows[DIR_W'(n)].ack, dir_rows[DIR_W'(n)].ok,
                       dir_rows[DIR_W'(n)].expired);
        end
        row_fixed = 1'b0;
        wait_drained();

        for (int ph = 0; ph < 3; ph++) begin
            pct = (ph == 0) ? 9 : (ph == 1) ? 48 : 0;
            for (int n = 0; n < 68; n++) begin
                while ($urandom_range(99) < pct) begin
                    @(negedge i_clk);
                    start <= 1'b0;
                end
                @(negedge i_clk);
                word = ($urandom_range(15) == 0) ? {gbn_pkg::MSG_W{$urandom_range(1) == 1}} :
                                                   $urandom();
                ack = gbn_pkg::PSEQ_W'($urandom_range(SEQS - 1));
                ok = 1'(($urandom_range(1)));
                expired = gbn_pkg::PSEQ_W'($urandom_range(SEQS - 1));
                pick = $urandom_range(99);
                if (pick < 42) begin
                    cmd = gbn_pkg::CMD_SEND;
                end else if (pick < 75) begin
                    cmd = gbn_pkg::CMD_ACK;
                    // Mostly good acks that land inside the live window.
                    if ($urandom_range(9) < 6 && pending != 0) begin
                        ack = gbn_pkg::PSEQ_W'((int'(win_base) +
                                                $urandom_range(pending - 1)) % SEQS);
                        ok = 1'b1;
                    end
                end else if (pick < 96) begin
                    cmd = gbn_pkg::CMD_TIMEOUT;
                end else begin
                    cmd = CMD_RESERVED;
                end
                drive_item(cmd, word, ack, ok, expired);
            end
            wait_drained();
        end

        repeat (12) @(negedge i_clk);
        if (due_count() != 0) begin
            bad_results += due_count();
        end
        if (bad_results == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

>>> go_back_n_sender.f
+incdir+hdl
hdl/gbn_pkg.sv
hdl/gbn_alu.sv
hdl/gbn_store.sv
hdl/go_back_n_sender.sv
hdl/gbn_checker.sv
bench/go_back_n_sender_test.sv
